>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked assertion, disabled while the active-low reset is asserted.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg)
`define ASSERT_CLK(label, clk, prop, msg)

`endif

`endif

>>> design/cqe_pkg.sv
// ----------------------------------------------------------------------------
// cqe_pkg
// Shared types and constants of the coefficient quantizer.
// ----------------------------------------------------------------------------
package cqe_pkg;

  localparam int GroupSize      = 16;
  localparam int IdxW           = $clog2(GroupSize);
  localparam int CoeffW         = 16;
  localparam int PosW           = 10;
  localparam int EobW           = 11;
  localparam int CfgIdxW        = 3;
  localparam int MaxBlockCoeffs = 1024;

  localparam logic [CoeffW-1:0] SatMax = 16'h7FFF;
  localparam logic [CoeffW-1:0] SatMin = 16'h8000;
  localparam logic [IdxW-1:0]   LastIdx = IdxW'(GroupSize - 1);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROUND_DC   = 3'd0,
    CFG_ROUND_AC   = 3'd1,
    CFG_QUANT_DC   = 3'd2,
    CFG_QUANT_AC   = 3'd3,
    CFG_DEQUANT_DC = 3'd4,
    CFG_DEQUANT_AC = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic            load;
    logic [IdxW-1:0] wr_idx;
    logic            dc;
    logic [IdxW-1:0] rd_idx;
    logic            close_group;
    logic            clear_block;
    logic            first_group;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic pipe_busy;
  } sts_t;

endpackage

>>> design/cqe_ctrl.sv
// ----------------------------------------------------------------------------
// cqe_ctrl
// Group sequencer: collects a group, waits for the pipeline, emits results.
// ----------------------------------------------------------------------------
module cqe_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          block_end_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic          group_last_o,
  output logic          block_last_o,
  output cqe_pkg::cmd_t cmd_o,
  input  cqe_pkg::sts_t sts_i
);
  import cqe_pkg::*;

  state_e          state_q, state_d;
  logic [IdxW-1:0] fill_q, fill_d;
  logic [IdxW-1:0] last_q, last_d;
  logic [IdxW-1:0] emit_q, emit_d;
  logic            first_q, first_d;
  logic            blk_q, blk_d;
  logic            in_xfer, out_xfer, emit_done;

  assign in_xfer   = in_valid_i && (state_q == ST_COLLECT);
  assign out_xfer  = (state_q == ST_EMIT) && !out_stall_i;
  assign emit_done = (emit_q == last_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    last_d  = last_q;
    emit_d  = emit_q;
    first_d = first_q;
    blk_d   = blk_q;
    case (state_q)
      ST_COLLECT: begin
        if (in_xfer) begin
          fill_d = fill_q + 1'b1;
          if (fill_q == LastIdx || block_end_i) begin
            state_d = ST_DRAIN;
            last_d  = fill_q;
            blk_d   = block_end_i;
            fill_d  = '0;
          end
        end
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = ST_EMIT;
          emit_d  = '0;
        end
      end
      ST_EMIT: begin
        if (out_xfer) begin
          emit_d = emit_q + 1'b1;
          if (emit_done) begin
            state_d = ST_COLLECT;
            first_d = blk_q;
          end
        end
      end
      default: state_d = ST_COLLECT;
    endcase
  end

  // Outputs. The result buffer read is registered, so it is addressed
  // with the next emit index.
  always_comb begin
    in_stall_o        = 1'b1;
    out_valid_o       = 1'b0;
    cmd_o             = '0;
    cmd_o.load        = in_xfer;
    cmd_o.wr_idx      = fill_q;
    cmd_o.dc          = first_q && (fill_q == '0);
    cmd_o.rd_idx      = emit_d;
    cmd_o.first_group = first_q;
    case (state_q)
      ST_COLLECT: in_stall_o = 1'b0;
      ST_DRAIN:   cmd_o.close_group = !sts_i.pipe_busy;
      ST_EMIT: begin
        out_valid_o       = 1'b1;
        cmd_o.clear_block = out_xfer && emit_done && blk_q;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  assign group_last_o = emit_done;
  assign block_last_o = emit_done && blk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
      fill_q  <= '0;
      last_q  <= '0;
      emit_q  <= '0;
      first_q <= 1'b1;
      blk_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      last_q  <= last_d;
      emit_q  <= emit_d;
      first_q <= first_d;
      blk_q   <= blk_d;
    end
  end

endmodule

>>> design/cqe_datapath.sv
// ----------------------------------------------------------------------------
// cqe_datapath
// Configuration registers, quantizer pipeline, result buffer and eob tracking.
// ----------------------------------------------------------------------------
module cqe_datapath #(
  parameter int MaxBlockCoeffs = cqe_pkg::MaxBlockCoeffs
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cqe_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [cqe_pkg::CoeffW-1:0]     cfg_data_i,
  input  logic signed [cqe_pkg::CoeffW-1:0] coeff_i,
  input  logic [cqe_pkg::PosW-1:0]       scan_pos_i,
  input  cqe_pkg::cmd_t                  cmd_i,
  output cqe_pkg::sts_t                  sts_o,
  output logic signed [cqe_pkg::CoeffW-1:0] qcoeff_o,
  output logic signed [cqe_pkg::CoeffW-1:0] dqcoeff_o,
  output logic [cqe_pkg::EobW-1:0]       eob_o
);
  import cqe_pkg::*;

  localparam logic [EobW-1:0] EobCap = EobW'(MaxBlockCoeffs);

  logic [CoeffW-1:0] round_dc_q, round_ac_q, quant_dc_q, quant_ac_q;
  logic [CoeffW-1:0] dequant_dc_q, dequant_ac_q;

  // Stage 1: captured input.
  logic              v1_q, dc1_q;
  logic [CoeffW-1:0] c1_q;
  logic [PosW-1:0]   pos1_q;
  logic [IdxW-1:0]   idx1_q;
  // Stage 2: saturated rounded magnitude.
  logic              v2_q, dc2_q, neg2_q;
  logic [CoeffW-1:0] sum2_q;
  logic [PosW-1:0]   pos2_q;
  logic [IdxW-1:0]   idx2_q;
  // Stage 3: high half of the quantizer product.
  logic              v3_q, dc3_q, neg3_q;
  logic [CoeffW-1:0] hi3_q;
  logic [PosW-1:0]   pos3_q;
  logic [IdxW-1:0]   idx3_q;
  // Stage 4: eob candidate.
  logic              v4_q, nz4_q;
  logic [PosW-1:0]   pos4_q;

  logic [CoeffW-1:0] qbuf_q [GroupSize];
  logic [CoeffW-1:0] dqbuf_q [GroupSize];
  logic [CoeffW-1:0] qrd_q, dqrd_q;

  logic              any_big_q, skip_q;
  logic [EobW-1:0]   grp_eob_q, eob_q, eob_d;

  logic              neg1;
  logic [CoeffW-1:0] mag1, rnd1, thr, sat1;
  logic [CoeffW:0]   sum1;
  logic              big1;
  logic [CoeffW-1:0] qnt2;
  logic [2*CoeffW-1:0] prod2;
  logic [CoeffW-1:0] qv3, dqs3;
  logic [2*CoeffW-1:0] dprod3;
  logic [EobW-1:0]   cand4, capped4;
  logic              skip_now;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_dc_q   <= '0;
      round_ac_q   <= '0;
      quant_dc_q   <= '0;
      quant_ac_q   <= '0;
      dequant_dc_q <= '0;
      dequant_ac_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ROUND_DC:   round_dc_q   <= cfg_data_i;
        CFG_ROUND_AC:   round_ac_q   <= cfg_data_i;
        CFG_QUANT_DC:   quant_dc_q   <= cfg_data_i;
        CFG_QUANT_AC:   quant_ac_q   <= cfg_data_i;
        CFG_DEQUANT_DC: dequant_dc_q <= cfg_data_i;
        CFG_DEQUANT_AC: dequant_ac_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage 1 to 2: magnitude (which wraps for the most negative value),
  // saturating add and skip threshold compare.
  always_comb begin
    neg1 = c1_q[CoeffW-1];
    mag1 = neg1 ? (~c1_q + 1'b1) : c1_q;
    rnd1 = dc1_q ? round_dc_q : round_ac_q;
    thr  = {dequant_ac_q[CoeffW-1], dequant_ac_q[CoeffW-1:1]};
    sum1 = {mag1[CoeffW-1], mag1} + {rnd1[CoeffW-1], rnd1};
    if (sum1[CoeffW] != sum1[CoeffW-1]) begin
      sat1 = sum1[CoeffW] ? SatMin : SatMax;
    end else begin
      sat1 = sum1[CoeffW-1:0];
    end
    big1 = $signed(mag1) > $signed(thr);
  end

  // Stage 2 to 3: signed multiply by the quantizer.
  always_comb begin
    qnt2  = dc2_q ? quant_dc_q : quant_ac_q;
    prod2 = $signed(sum2_q) * $signed(qnt2);
  end

  // Stage 3 to buffer: restore sign, wrapping dequantize.
  always_comb begin
    qv3    = neg3_q ? (~hi3_q + 1'b1) : hi3_q;
    dqs3   = dc3_q ? dequant_dc_q : dequant_ac_q;
    dprod3 = {{CoeffW{1'b0}}, qv3} * {{CoeffW{1'b0}}, dqs3};
  end

  always_comb begin
    cand4   = {1'b0, pos4_q} + 1'b1;
    capped4 = (cand4 > EobCap) ? EobCap : cand4;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.load;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c1_q   <= coeff_i;
    pos1_q <= scan_pos_i;
    idx1_q <= cmd_i.wr_idx;
    dc1_q  <= cmd_i.dc;
    sum2_q <= sat1;
    neg2_q <= neg1;
    dc2_q  <= dc1_q;
    pos2_q <= pos1_q;
    idx2_q <= idx1_q;
    hi3_q  <= prod2[2*CoeffW-1:CoeffW];
    neg3_q <= neg2_q;
    dc3_q  <= dc2_q;
    pos3_q <= pos2_q;
    idx3_q <= idx2_q;
    nz4_q  <= (dprod3[CoeffW-1:0] != '0);
    pos4_q <= pos3_q;
    if (v3_q) begin
      qbuf_q[idx3_q]  <= qv3;
      dqbuf_q[idx3_q] <= dprod3[CoeffW-1:0];
    end
    qrd_q  <= qbuf_q[cmd_i.rd_idx];
    dqrd_q <= dqbuf_q[cmd_i.rd_idx];
  end

  // A later group with no large magnitude is emitted as zeros.
  assign skip_now = !cmd_i.first_group && !any_big_q;

  always_comb begin
    eob_d = eob_q;
    if (cmd_i.clear_block) begin
      eob_d = '0;
    end else if (cmd_i.close_group && !skip_now && (grp_eob_q > eob_q)) begin
      eob_d = grp_eob_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_big_q <= 1'b0;
      grp_eob_q <= '0;
      eob_q     <= '0;
      skip_q    <= 1'b0;
    end else begin
      eob_q <= eob_d;
      if (cmd_i.close_group) begin
        skip_q    <= skip_now;
        any_big_q <= 1'b0;
        grp_eob_q <= '0;
      end else begin
        if (v1_q && big1) begin
          any_big_q <= 1'b1;
        end
        if (v4_q && nz4_q && (capped4 > grp_eob_q)) begin
          grp_eob_q <= capped4;
        end
      end
    end
  end

  assign sts_o.pipe_busy = v1_q || v2_q || v3_q || v4_q;
  assign qcoeff_o  = skip_q ? '0 : qrd_q;
  assign dqcoeff_o = skip_q ? '0 : dqrd_q;
  assign eob_o     = eob_q;

endmodule

>>> design/coeff_quantizer_with_eob.sv
// A group is collected, then drained through the four-stage quantizer pipeline;
// its first result is offered once the pipeline is empty, and the next group is
// taken only after all results of the group have been sent.
// Inputs stall while a group drains and while its results are sent.
// Reset (asynchronous, active low) clears all configuration registers to zero,
// empties the pipeline, zeroes the running eob and starts a new block.
// ----------------------------------------------------------------------------
// coeff_quantizer_with_eob
// Groupwise coefficient quantizer with dequantization and running eob.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module coeff_quantizer_with_eob #(
  parameter int MaxBlockCoeffs = cqe_pkg::MaxBlockCoeffs
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cqe_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [cqe_pkg::CoeffW-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [cqe_pkg::CoeffW-1:0] coeff_i,
  input  logic [cqe_pkg::PosW-1:0]          scan_pos_i,
  input  logic                              block_end_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [cqe_pkg::CoeffW-1:0] qcoeff_o,
  output logic signed [cqe_pkg::CoeffW-1:0] dqcoeff_o,
  output logic [cqe_pkg::EobW-1:0]          eob_o,
  output logic                              group_last_o,
  output logic                              block_last_o
);
  import cqe_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  cqe_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .block_end_i  (block_end_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .group_last_o (group_last_o),
    .block_last_o (block_last_o),
    .cmd_o        (cmd),
    .sts_i        (sts)
  );

  cqe_datapath #(
    .MaxBlockCoeffs (MaxBlockCoeffs)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .coeff_i     (coeff_i),
    .scan_pos_i  (scan_pos_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .qcoeff_o    (qcoeff_o),
    .dqcoeff_o   (dqcoeff_o),
    .eob_o       (eob_o)
  );

  // Input and output transfers never overlap.
  `ASSERT_CLK(a_no_in_during_out, clk_i, !(in_valid_i && !in_stall_o && out_valid_o), "input taken while results pending")
  `ASSERT_CLK_RST(a_block_implies_group, clk_i, rst_ni, (out_valid_o && block_last_o) |-> group_last_o, "block_last without group_last")
  // The eob is held across the results of a group.
  `ASSERT_CLK_RST(a_eob_stable_in_group, clk_i, rst_ni, (out_valid_o && !out_stall_i && !group_last_o) |=> (eob_o == $past(eob_o)), "eob changed within a group")
  `ASSERT_CLK_RST(a_eob_cleared, clk_i, rst_ni, (out_valid_o && !out_stall_i && block_last_o) |=> (eob_o == '0), "eob not cleared after block end")

endmodule

>>> test/coeff_quantizer_with_eob_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// coeff_quantizer_with_eob_tb
// Self-checking bench: streams coefficients through the quantizer under
// several register settings and compares every result against a predictor.
// ----------------------------------------------------------------------------
module coeff_quantizer_with_eob_tb;
  import cqe_pkg::*;

  localparam int          CycleLimit  = 200000;
  localparam int          DrainCycles = 12;
  localparam int          HoldCycles  = 300;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareHi = 3'd7;

  typedef logic [CoeffW-1:0] reg_set_t [6];

  typedef struct {
    logic signed [CoeffW-1:0] qcoeff;
    logic signed [CoeffW-1:0] dqcoeff;
    logic [EobW-1:0]          eob;
    logic                     group_last;
    logic                     block_last;
  } quant_result_t;

  class quant_scoreboard;
    logic [CoeffW-1:0] regs [6];
    logic [CoeffW-1:0] grp_coeffs [GroupSize];
    logic [PosW-1:0]   grp_positions [GroupSize];
    int unsigned       fill;
    bit                first_grp;
    int unsigned       block_eob;
    quant_result_t     pending_quant_results [$];
    int                errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      fill      = 0;
      first_grp = 1'b1;
      block_eob = 0;
      errors    = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CoeffW-1:0] val);
      if (idx <= CFG_DEQUANT_AC) regs[idx] = val;
    endfunction

    function int pending();
      return pending_quant_results.size();
    endfunction

    // Works out the results of a group once it is full or the block ends.
    function void note_coeff(logic [CoeffW-1:0] coeff, logic [PosW-1:0] pos, logic blk_end);
      logic signed [CoeffW-1:0] thr;
      logic [CoeffW-1:0]        qv [GroupSize];
      logic [CoeffW-1:0]        dv [GroupSize];
      logic [CoeffW-1:0]        c, mag, rnd, qnt, dqs, sat, hi;
      logic                     neg, dc, any_big;
      int                       s, p;
      int unsigned              cand;
      quant_result_t            r;

      grp_coeffs[fill]    = coeff;
      grp_positions[fill] = pos;
      fill++;
      if (fill < GroupSize && !blk_end) return;

      thr     = $signed(regs[CFG_DEQUANT_AC]) >>> 1;
      any_big = 1'b0;
      for (int k = 0; k < fill; k++) begin
        c   = grp_coeffs[k];
        neg = c[CoeffW-1];
        mag = neg ? -c : c;
        dc  = first_grp && (k == 0);
        rnd = dc ? regs[CFG_ROUND_DC] : regs[CFG_ROUND_AC];
        qnt = dc ? regs[CFG_QUANT_DC] : regs[CFG_QUANT_AC];
        dqs = dc ? regs[CFG_DEQUANT_DC] : regs[CFG_DEQUANT_AC];
        if ($signed(mag) > thr) any_big = 1'b1;
        s = $signed(mag) + $signed(rnd);
        if (s > 32767) s = 32767;
        if (s < -32768) s = -32768;
        sat   = s[CoeffW-1:0];
        p     = $signed(sat) * $signed(qnt);
        hi    = p[31:16];
        qv[k] = neg ? -hi : hi;
        dv[k] = qv[k] * dqs;
      end

      if (!first_grp && !any_big) begin
        for (int k = 0; k < fill; k++) begin
          qv[k] = '0;
          dv[k] = '0;
        end
      end else begin
        for (int k = 0; k < fill; k++) begin
          if (dv[k] != '0) begin
            cand = grp_positions[k] + 1;
            if (cand > MaxBlockCoeffs) cand = MaxBlockCoeffs;
            if (cand > block_eob) block_eob = cand;
          end
        end
      end

      for (int k = 0; k < fill; k++) begin
        r.qcoeff     = qv[k];
        r.dqcoeff    = dv[k];
        r.eob        = block_eob[EobW-1:0];
        r.group_last = (k + 1 == fill);
        r.block_last = (k + 1 == fill) && blk_end;
        pending_quant_results.push_back(r);
      end

      fill = 0;
      if (blk_end) begin
        first_grp = 1'b1;
        block_eob = 0;
      end else begin
        first_grp = 1'b0;
      end
    endfunction

    function void check_result(quant_result_t got);
      quant_result_t exp_r;
      if (pending_quant_results.size() == 0) begin
        $error("unexpected result: qcoeff %0d dqcoeff %0d eob %0d",
               got.qcoeff, got.dqcoeff, got.eob);
        errors++;
        return;
      end
      exp_r = pending_quant_results.pop_front();
      if (got.qcoeff !== exp_r.qcoeff) begin
        $error("qcoeff: expected %0d, got %0d", exp_r.qcoeff, got.qcoeff);
        errors++;
      end
      if (got.dqcoeff !== exp_r.dqcoeff) begin
        $error("dqcoeff: expected %0d, got %0d", exp_r.dqcoeff, got.dqcoeff);
        errors++;
      end
      if (got.eob !== exp_r.eob) begin
        $error("eob: expected %0d, got %0d", exp_r.eob, got.eob);
        errors++;
      end
      if (got.group_last !== exp_r.group_last) begin
        $error("group_last: expected %0b, got %0b", exp_r.group_last, got.group_last);
        errors++;
      end
      if (got.block_last !== exp_r.block_last) begin
        $error("block_last: expected %0b, got %0b", exp_r.block_last, got.block_last);
        errors++;
      end
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [CfgIdxW-1:0]         cfg_index_i;
  logic [CoeffW-1:0]          cfg_data_i;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic signed [CoeffW-1:0]   coeff_i;
  logic [PosW-1:0]            scan_pos_i;
  logic                       block_end_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic signed [CoeffW-1:0]   qcoeff_o;
  logic signed [CoeffW-1:0]   dqcoeff_o;
  logic [EobW-1:0]            eob_o;
  logic                       group_last_o;
  logic                       block_last_o;

  quant_scoreboard quant_sb = new();

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_request   = 1'b0;
  int unsigned hold_left      = 0;
  int unsigned cycle_count    = 0;

  logic signed [CoeffW-1:0] dir_coeffs [GroupSize] = '{
    -16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1, 16'sd100, -16'sd100, 16'sd1000,
    -16'sd1000, 16'sd32000, -16'sd32000, 16'sd5, -16'sd5, 16'sd20, 16'sd21, -16'sd21
  };

  coeff_quantizer_with_eob u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .coeff_i      (coeff_i),
    .scan_pos_i   (scan_pos_i),
    .block_end_i  (block_end_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .qcoeff_o     (qcoeff_o),
    .dqcoeff_o    (dqcoeff_o),
    .eob_o        (eob_o),
    .group_last_o (group_last_o),
    .block_last_o (block_last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("coeff_quantizer_with_eob regression: fail");
      $finish;
    end
  end

  // Receiver: a requested hold-off keeps stall high for a long stretch so the
  // block backs up into its input.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HoldCycles - 1;
      out_stall_i  <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    quant_result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.qcoeff     = qcoeff_o;
      got.dqcoeff    = dqcoeff_o;
      got.eob        = eob_o;
      got.group_last = group_last_o;
      got.block_last = block_last_o;
      quant_sb.check_result(got);
    end
  end

  // Valid stays high across back-to-back transfers; only the payload moves.
  task automatic send_coeff(logic [CoeffW-1:0] c, logic [PosW-1:0] pos, logic be);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    coeff_i     <= c;
    scan_pos_i  <= pos;
    block_end_i <= be;
    do @(posedge clk_i); while (in_stall_o);
    quant_sb.note_coeff(c, pos, be);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CoeffW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    quant_sb.set_reg(idx, val);
  endtask

  task automatic program_regs(reg_set_t vals, bit with_spare);
    for (int i = 0; i <= CFG_DEQUANT_AC; i++) write_reg(i[CfgIdxW-1:0], vals[i]);
    if (with_spare) begin
      write_reg(CfgIdxSpareLo, 16'($urandom));
      write_reg(CfgIdxSpareHi, 16'($urandom));
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (quant_sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [CoeffW-1:0] pick_coeff();
    case ($urandom_range(3))
      0: return 16'($urandom_range(128)) - 16'd64;
      1: return 16'($urandom_range(4000)) - 16'd2000;
      2: begin
        case ($urandom_range(3))
          0: return SatMin;
          1: return SatMax;
          2: return 16'hFFFF;
          default: return '0;
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic run_blocks(int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(3) == 0) len = 16 * $urandom_range(1, 3);
      else len = $urandom_range(1, 48);
      // The last block is cut short so the phase sends exactly n_items.
      if (len > n_items - sent) len = n_items - sent;
      for (int k = 0; k < len; k++)
        send_coeff(pick_coeff(), 10'($urandom_range(1023)), k == len - 1);
      sent += len;
    end
  endtask

  initial begin
    reg_set_t cfg_vals;

    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_ROUND_DC;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    coeff_i     <= '0;
    scan_pos_i  <= '0;
    block_end_i <= 1'b0;
    out_stall_i <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: saturating DC round, most negative quantizer, wrap of the
    // most negative coefficient, a skipped partial group and a one-item block.
    send_idle_pct  = 8;
    recv_stall_pct = 57;
    cfg_vals = '{16'h7FFF, -16'sd5, SatMin, 16'd20000, -16'sd3, 16'd40};
    program_regs(cfg_vals, 1'b0);
    for (int k = 0; k < GroupSize; k++)
      send_coeff(dir_coeffs[k], (k == 1) ? 10'd1023 : 10'(k * 7), 1'b0);
    send_coeff(16'd3, 10'd700, 1'b0);
    send_coeff(-16'sd20, 10'd800, 1'b0);
    send_coeff(16'd0, 10'd900, 1'b1);
    send_coeff(SatMin, 10'd1023, 1'b1);
    wait_drained();

    foreach (cfg_vals[i]) cfg_vals[i] = 16'($urandom);
    program_regs(cfg_vals, 1'b1);
    run_blocks(50);
    wait_drained();

    send_idle_pct  = 57;
    recv_stall_pct = 8;
    foreach (cfg_vals[i]) cfg_vals[i] = SatMax;
    program_regs(cfg_vals, 1'b0);
    run_blocks(40);
    wait_drained();

    foreach (cfg_vals[i]) cfg_vals[i] = SatMin;
    program_regs(cfg_vals, 1'b0);
    run_blocks(40);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cfg_vals[CFG_ROUND_DC]   = 16'($urandom_range(255));
    cfg_vals[CFG_ROUND_AC]   = 16'($urandom_range(255));
    cfg_vals[CFG_QUANT_DC]   = 16'($urandom_range(1, 32767));
    cfg_vals[CFG_QUANT_AC]   = 16'($urandom_range(1, 32767));
    cfg_vals[CFG_DEQUANT_DC] = 16'($urandom_range(1, 4095));
    cfg_vals[CFG_DEQUANT_AC] = 16'($urandom_range(1, 255));
    program_regs(cfg_vals, 1'b0);
    hold_request = 1'b1;
    run_blocks(70);
    wait_drained();

    if (quant_sb.errors == 0 && quant_sb.pending() == 0) begin
      $display("coeff_quantizer_with_eob regression: pass");
    end else begin
      $display("coeff_quantizer_with_eob regression: fail");
    end
    $finish;
  end

endmodule

>>> coeff_quantizer_with_eob.f
+incdir+design
design/cqe_pkg.sv
design/cqe_ctrl.sv
design/cqe_datapath.sv
design/coeff_quantizer_with_eob.sv
test/coeff_quantizer_with_eob_tb.sv
